// ===== rtl/core/pic_pkg.sv =====
// Shared types and constants of the priority interrupt controller.
package pic_pkg;

  localparam int unsigned LINES_DEF     = 64;
  localparam int unsigned PRIO_BITS_DEF = 4;

  localparam logic [31:0] ID_WORD = 32'h0031_C011;

  typedef enum logic [1:0] {
    REQ_LINE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_ID      = 3'd0,
    REG_IRQ_ACK = 3'd1,
    REG_FIQ_ACK = 3'd2,
    REG_FIQ_NUM = 3'd3,
    REG_IRQ_NUM = 3'd4,
    REG_TABLE   = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] line_index;
    logic       line_level;
    logic [2:0] reg_select;
    logic [5:0] entry_index;
    logic [3:0] write_priority;
    logic       write_fiq;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        read_ack_active;
    logic [3:0]  read_entry_priority;
    logic        read_entry_fiq;
    logic        irq_request;
    logic        fiq_request;
  } out_t;

endpackage

// ===== rtl/core/pic_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pic_sel.sv =====
// Running winner selection for both channels over a scan of the line table.
module pic_sel #(
  parameter int unsigned LINES         = pic_pkg::LINES_DEF,
  parameter int unsigned PRIORITY_BITS = pic_pkg::PRIO_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  logic                           vld_i,
  input  logic [$clog2(LINES)-1:0]       idx_i,
  input  logic [PRIORITY_BITS-1:0]       prio_i,
  input  logic                           fiq_i,
  input  logic                           level_i,
  output logic [1:0]                     found_o,
  output logic [1:0][$clog2(LINES)-1:0]  idx_o
);

  localparam int unsigned AW = $clog2(LINES);

  logic [1:0]                    found_q, found_d;
  logic [1:0][PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [1:0][AW-1:0]            idx_q, idx_d;

  // Lines are visited in ascending order, so taking ties replaces the winner
  // with the higher index.
  always_comb begin
    found_d = found_q;
    prio_d  = prio_q;
    idx_d   = idx_q;
    for (int ch = 0; ch < 2; ch++) begin
      if (clr_i) begin
        found_d[ch] = 1'b0;
        prio_d[ch]  = '0;
        idx_d[ch]   = '0;
      end else if (vld_i && (prio_i != '0) && (fiq_i == ch[0]) && level_i &&
                   (!found_q[ch] || (prio_i <= prio_q[ch]))) begin
        found_d[ch] = 1'b1;
        prio_d[ch]  = prio_i;
        idx_d[ch]   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    idx_q  <= idx_d;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;

endmodule

// ===== rtl/core/priority_interrupt_controller_unit.sv =====
// Top level of the priority interrupt controller: sequencer, line and table memories.
//
// The controller keeps, for each of LINES interrupt lines, its level in one
// memory and its table entry (priority, IRQ/FIQ select) in a second memory.
// After reset both memories are cleared in a pass over all LINES entries,
// during which no item is taken. A bus read goes from the idle state
// straight to the done state, and a line event or a bus write runs through
// the scan, scan-end, commit and done states in that order. In the scan the
// memories are read back one entry per cycle over a single read port, and
// the winner of each unlocked channel (lowest nonzero priority, higher line
// on a tie) is built up as the entries stream by, then latched in the commit
// state. Every item yields one result item, which carries the read data and
// the IRQ and FIQ request levels as they stand after the item. The result
// sits in an output register, so the next item is accepted while it waits
// to be taken.
module priority_interrupt_controller_unit #(
  parameter int unsigned LINES         = pic_pkg::LINES_DEF,
  parameter int unsigned PRIORITY_BITS = pic_pkg::PRIO_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pic_pkg::in_t   in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pic_pkg::out_t  out_item_o
);

  localparam int unsigned AW = $clog2(LINES);
  localparam int unsigned TW = PRIORITY_BITS + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(LINES - 1);

  pic_pkg::state_e state_q, state_d;

  pic_pkg::in_t  item_q;
  logic          entry_ok_q;
  pic_pkg::out_t out_q, out_d;
  logic          out_valid_q;

  logic [AW-1:0] cnt_q, cnt_d;
  logic          pend_q;
  logic [AW-1:0] pend_idx_q;

  // Channel state: the normal (IRQ) channel and the fast (FIQ) channel.
  logic          irq_lock_q, fiq_lock_q;
  logic          irq_req_q, fiq_req_q;
  logic [AW-1:0] irq_num_q, fiq_num_q;

  logic accept;
  logic line_ok, entry_ok;
  logic [31:0] line_ext, entry_ext, wprio_ext, rprio_ext;
  logic [AW-1:0] line_addr, entry_addr;

  // Memory ports.
  logic          lvl_we, lvl_wdata, lvl_rdata;
  logic          tab_we, tab_re;
  logic [AW-1:0] lvl_waddr, tab_waddr, rd_addr;
  logic [TW-1:0] tab_wdata, tab_rdata;

  logic [1:0]          sel_found;
  logic [1:0][AW-1:0]  sel_idx;

  assign accept = in_valid_i && !in_stall_o;

  // The input indexes are six bits wide; the table may be narrower or wider.
  assign line_ext   = 32'(in_item_i.line_index);
  assign entry_ext  = 32'(in_item_i.entry_index);
  assign wprio_ext  = 32'(in_item_i.write_priority);
  assign line_ok    = line_ext < 32'(LINES);
  assign entry_ok   = entry_ext < 32'(LINES);
  assign line_addr  = line_ext[AW-1:0];
  assign entry_addr = entry_ext[AW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pic_pkg::ST_CLEAR: begin
        if (cnt_q == LAST_IDX) begin
          state_d = pic_pkg::ST_IDLE;
        end
      end
      pic_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_item_i.req_type == pic_pkg::REQ_LINE) ||
              (in_item_i.req_type == pic_pkg::REQ_WRITE)) begin
            state_d = pic_pkg::ST_SCAN;
          end else begin
            state_d = pic_pkg::ST_DONE;
          end
        end
      end
      pic_pkg::ST_SCAN: begin
        if (cnt_q == LAST_IDX) begin
          state_d = pic_pkg::ST_SCAN_END;
        end
      end
      pic_pkg::ST_SCAN_END: state_d = pic_pkg::ST_COMMIT;
      pic_pkg::ST_COMMIT:   state_d = pic_pkg::ST_DONE;
      pic_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = pic_pkg::ST_IDLE;
        end
      end
      default: state_d = pic_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: handshake, memory ports and the scan counter.
  always_comb begin
    in_stall_o = 1'b1;
    lvl_we     = 1'b0;
    lvl_waddr  = line_addr;
    lvl_wdata  = in_item_i.line_level;
    tab_we     = 1'b0;
    tab_waddr  = entry_addr;
    tab_wdata  = {in_item_i.write_fiq, wprio_ext[PRIORITY_BITS-1:0]};
    tab_re     = 1'b0;
    rd_addr    = entry_addr;
    cnt_d      = cnt_q;
    case (state_q)
      pic_pkg::ST_CLEAR: begin
        lvl_we    = 1'b1;
        lvl_waddr = cnt_q;
        lvl_wdata = 1'b0;
        tab_we    = 1'b1;
        tab_waddr = cnt_q;
        tab_wdata = '0;
        cnt_d     = cnt_q + AW'(1);
      end
      pic_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cnt_d      = '0;
        if (accept) begin
          lvl_we = (in_item_i.req_type == pic_pkg::REQ_LINE) && line_ok;
          tab_we = (in_item_i.req_type == pic_pkg::REQ_WRITE) &&
                   (in_item_i.reg_select == pic_pkg::REG_TABLE) && entry_ok;
          tab_re = (in_item_i.req_type == pic_pkg::REQ_READ) &&
                   (in_item_i.reg_select == pic_pkg::REG_TABLE);
        end
      end
      pic_pkg::ST_SCAN: begin
        // Writes land at the accepting edge, so the scan that follows sees them.
        tab_re  = 1'b1;
        rd_addr = cnt_q;
        cnt_d   = cnt_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  pic_ram #(
    .WIDTH (1),
    .DEPTH (LINES)
  ) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .re_i    (tab_re),
    .raddr_i (rd_addr),
    .rdata_o (lvl_rdata)
  );

  pic_ram #(
    .WIDTH (TW),
    .DEPTH (LINES)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (rd_addr),
    .rdata_o (tab_rdata)
  );

  pic_sel #(
    .LINES         (LINES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (accept),
    .vld_i   (pend_q),
    .idx_i   (pend_idx_q),
    .prio_i  (tab_rdata[PRIORITY_BITS-1:0]),
    .fiq_i   (tab_rdata[TW-1]),
    .level_i (lvl_rdata),
    .found_o (sel_found),
    .idx_o   (sel_idx)
  );

  // Result of the current item, formed once all of its work is done.
  assign rprio_ext = 32'(tab_rdata[PRIORITY_BITS-1:0]);

  always_comb begin
    out_d             = '0;
    out_d.irq_request = irq_req_q;
    out_d.fiq_request = fiq_req_q;
    if (item_q.req_type == pic_pkg::REQ_READ) begin
      case (item_q.reg_select)
        pic_pkg::REG_ID:      out_d.read_value      = pic_pkg::ID_WORD;
        pic_pkg::REG_IRQ_ACK: out_d.read_ack_active = irq_lock_q;
        pic_pkg::REG_FIQ_ACK: out_d.read_ack_active = fiq_lock_q;
        pic_pkg::REG_FIQ_NUM: out_d.read_value      = 32'(fiq_num_q);
        pic_pkg::REG_IRQ_NUM: out_d.read_value      = 32'(irq_num_q);
        pic_pkg::REG_TABLE: begin
          if (entry_ok_q) begin
            out_d.read_entry_priority = rprio_ext[3:0];
            out_d.read_entry_fiq      = tab_rdata[TW-1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pic_pkg::ST_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      irq_lock_q  <= 1'b0;
      fiq_lock_q  <= 1'b0;
      irq_req_q   <= 1'b0;
      fiq_req_q   <= 1'b0;
      irq_num_q   <= '0;
      fiq_num_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= (state_q == pic_pkg::ST_SCAN);
      // A new result replaces one that is taken at the same edge.
      if ((state_q == pic_pkg::ST_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // An ack write unlocks its channel before the selection runs.
      if (accept && (in_item_i.req_type == pic_pkg::REQ_WRITE)) begin
        if (in_item_i.reg_select == pic_pkg::REG_IRQ_ACK) begin
          irq_lock_q <= 1'b0;
        end
        if (in_item_i.reg_select == pic_pkg::REG_FIQ_ACK) begin
          fiq_lock_q <= 1'b0;
        end
      end
      // A locked channel keeps its number and request as latched.
      if (state_q == pic_pkg::ST_COMMIT) begin
        if (!irq_lock_q) begin
          irq_num_q  <= sel_found[0] ? sel_idx[0] : '0;
          irq_req_q  <= sel_found[0];
          irq_lock_q <= sel_found[0];
        end
        if (!fiq_lock_q) begin
          fiq_num_q  <= sel_found[1] ? sel_idx[1] : '0;
          fiq_req_q  <= sel_found[1];
          fiq_lock_q <= sel_found[1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_item_i;
      entry_ok_q <= entry_ok;
    end
    pend_idx_q <= cnt_q;
    if ((state_q == pic_pkg::ST_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A locked channel always drives its request.
  a_irq_lock_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_lock_q |-> irq_req_q) else $error("IRQ locked without request");

  a_fiq_lock_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fiq_lock_q |-> fiq_req_q) else $error("FIQ locked without request");

  // With no request pending, the latched number is zero.
  a_irq_num_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !irq_req_q |-> (irq_num_q == '0)) else $error("IRQ number without request");

  // A result only appears after the sequencer finished its item.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pic_pkg::ST_DONE))
    else $error("Result offered outside of completion");

  // No item is taken during the clearing pass or a scan.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pic_pkg::ST_CLEAR) || (state_q == pic_pkg::ST_SCAN)) |=>
    !$past(accept)) else $error("Item accepted while busy");

endmodule
